// ===== rtl/lpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfs_pkg
// Shared types and constants of the length-prefixed frame splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfs_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned FLAGS_W = 16;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned KIND_W  = 2;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_ZERO_HDR = 2'd2
   } kind_type;

   // One result item
   typedef struct packed {
      kind_type             kind;
      logic [BYTE_W-1:0]    payload_byte;
      logic [FLAGS_W-1:0]   frame_flags;
      logic                 last;
   } result_type;

   // Front to queue write transaction
   typedef struct packed {
      logic       push;
      result_type item;
   } queue_wr_type;

   // Queue to back read side
   typedef struct packed {
      logic       not_empty;
      result_type item;
   } queue_rd_type;

endpackage : lpfs_pkg

`default_nettype wire

// ===== rtl/length_prefixed_frame_splitter.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_splitter
// Splits a byte stream into frames with a little-endian 32-bit header.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one raw stream byte per transaction (req_valid, req_stall).
//   rsp_ channel: results (rsp_valid, rsp_stall): a payload byte with its
//     frame flags and last marker, an empty-frame result, or a zero-header
//     error. Header bytes give no result except the fourth of a zero or
//     zero-length header.
//   csr_ channel: writes size_mask (csr_valid, csr_ready, always ready).
//     The mask is sampled when a header's fourth byte arrives.
//   Throughput: one byte per clock while req_stall is low. A result passes
//   through the result queue, written when its byte is accepted, and then
//   the output register, which loads from the queue head.
//   A receiver stall holds the output register; the result queue keeps
//   taking bytes until it holds QUEUE_DEPTH results, then req_stall rises.
//   Reset clears the frame state and the queue and sets size_mask to all
//   ones; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_splitter
   import lpfs_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [BYTE_W-1:0]   req_in_byte,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [KIND_W-1:0]        rsp_kind,
   output logic [BYTE_W-1:0]        rsp_payload_byte,
   output logic [FLAGS_W-1:0]       rsp_frame_flags,
   output logic                     rsp_last,

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [LEN_W-1:0]    csr_size_mask
);

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         pop;
   logic         accept;
   result_type   rsp_item;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign csr_ready = 1'b1;

   lpfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .csr_write (csr_valid),
      .csr_data  (csr_size_mask),
      .queue_wr  (queue_wr)
   );

   lpfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (pop),
      .queue_rd (queue_rd),
      .full     (queue_full)
   );

   lpfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_rd  (queue_rd),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Unpack the result register
   assign rsp_kind         = rsp_item.kind;
   assign rsp_payload_byte = rsp_item.payload_byte;
   assign rsp_frame_flags  = rsp_item.frame_flags;
   assign rsp_last         = rsp_item.last;

endmodule : length_prefixed_frame_splitter

`default_nettype wire

// ===== rtl/lpfs_front.sv =====
// ----------------------------------------------------------------------------
// lpfs_front
// Header collector and classifier: takes one byte per transaction, tracks the
// frame state and writes at most one result per byte into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_front
   import lpfs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [BYTE_W-1:0]  in_byte,
   input  wire logic               csr_write,
   input  wire logic [LEN_W-1:0]   csr_data,
   output queue_wr_type            queue_wr
);

   logic [23:0]          header_low_bytes_ff, header_low_bytes_in;
   logic [1:0]           header_count_ff, header_count_in;
   logic                 in_payload_ff, in_payload_in;
   logic [LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic [FLAGS_W-1:0]   held_flags_ff, held_flags_in;
   logic [LEN_W-1:0]     size_mask_ff, size_mask_in;

   logic [FLAGS_W-1:0]   hdr_flags;
   logic [LEN_W-1:0]     hdr_len;
   logic                 hdr_zero;

   // Decode the header as if this byte completes it
   assign hdr_flags = {in_byte, header_low_bytes_ff[23:16]};
   assign hdr_len   = header_low_bytes_ff[15:0] & size_mask_ff;
   assign hdr_zero  = (header_low_bytes_ff == 24'd0) && (in_byte == 8'd0);

   // Advance frame state and build the result
   always_comb begin
      header_low_bytes_in = header_low_bytes_ff;
      header_count_in     = header_count_ff;
      in_payload_in       = in_payload_ff;
      bytes_left_in       = bytes_left_ff;
      held_flags_in       = held_flags_ff;
      size_mask_in        = csr_write ? csr_data : size_mask_ff;

      queue_wr.push              = 1'b0;
      queue_wr.item.kind         = KIND_PAYLOAD;
      queue_wr.item.payload_byte = in_byte;
      queue_wr.item.frame_flags  = held_flags_ff;
      queue_wr.item.last         = (bytes_left_ff == LEN_W'(1));

      if (accept) begin
         if (in_payload_ff) begin
            queue_wr.push = 1'b1;
            bytes_left_in = bytes_left_ff - LEN_W'(1);
            if (bytes_left_ff == LEN_W'(1)) begin
               in_payload_in = 1'b0;
            end
         end else if (header_count_ff != 2'd3) begin
            case (header_count_ff)
               2'd0:    header_low_bytes_in[7:0]   = in_byte;
               2'd1:    header_low_bytes_in[15:8]  = in_byte;
               2'd2:    header_low_bytes_in[23:16] = in_byte;
               default: header_low_bytes_in        = header_low_bytes_ff;
            endcase
            header_count_in = header_count_ff + 2'd1;
         end else begin
            header_low_bytes_in = 24'd0;
            header_count_in     = 2'd0;
            if (hdr_zero) begin
               queue_wr.push              = 1'b1;
               queue_wr.item.kind         = KIND_ZERO_HDR;
               queue_wr.item.payload_byte = '0;
               queue_wr.item.frame_flags  = '0;
               queue_wr.item.last         = 1'b0;
            end else if (hdr_len == '0) begin
               queue_wr.push              = 1'b1;
               queue_wr.item.kind         = KIND_EMPTY;
               queue_wr.item.payload_byte = '0;
               queue_wr.item.frame_flags  = hdr_flags;
               queue_wr.item.last         = 1'b1;
            end else begin
               in_payload_in = 1'b1;
               bytes_left_in = hdr_len;
               held_flags_in = hdr_flags;
            end
         end
      end
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         header_low_bytes_ff <= '0;
         header_count_ff     <= '0;
         in_payload_ff       <= 1'b0;
         bytes_left_ff       <= '0;
         held_flags_ff       <= '0;
         size_mask_ff        <= '1;
      end else begin
         header_low_bytes_ff <= header_low_bytes_in;
         header_count_ff     <= header_count_in;
         in_payload_ff       <= in_payload_in;
         bytes_left_ff       <= bytes_left_in;
         held_flags_ff       <= held_flags_in;
         size_mask_ff        <= size_mask_in;
      end
   end

endmodule : lpfs_front

`default_nettype wire

// ===== rtl/lpfs_queue.sv =====
// ----------------------------------------------------------------------------
// lpfs_queue
// Short result queue between the front classifier and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_queue
   import lpfs_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  queue_wr_type queue_wr,
   input  wire logic    pop,
   output queue_rd_type queue_rd,
   output logic         full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_pop;

   assign do_pop             = pop && (count_ff != '0);
   assign full               = (count_ff == CNT_W'(DEPTH));
   assign queue_rd.not_empty = (count_ff != '0);
   assign queue_rd.item      = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (queue_wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({queue_wr.push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (queue_wr.push) begin
         entry_ff[wr_ptr_ff] <= queue_wr.item;
      end
   end

endmodule : lpfs_queue

`default_nettype wire

// ===== rtl/lpfs_back.sv =====
// ----------------------------------------------------------------------------
// lpfs_back
// Output stage: moves the queue head into the result register and holds it
// while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfs_back
   import lpfs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  queue_rd_type queue_rd,
   output logic         pop,
   input  wire logic    rsp_stall,
   output logic         rsp_valid,
   output result_type   rsp_item
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff, rsp_item_in;
   logic       load;

   // Load when the register is empty or its transaction completes
   assign load         = !rsp_valid_ff || !rsp_stall;
   assign pop          = load && queue_rd.not_empty;
   assign rsp_valid_in = load ? queue_rd.not_empty : rsp_valid_ff;
   assign rsp_item_in  = pop ? queue_rd.item : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule : lpfs_back

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed frame splitter. Streams byte
// sequences (headers, payloads, zero and empty headers) through req_, keeps
// a bit-accurate model of the deframing state to predict every rsp_
// transaction, and compares each received result field by field.
// ----------------------------------------------------------------------------

module testbench
   import lpfs_pkg::*;
();

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_in_byte   = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic [FLAGS_W-1:0]  rsp_frame_flags;
   logic                rsp_last;
   logic                csr_valid     = 1'b0;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_size_mask = '0;

   // Deframing state mirrored from the byte stream
   logic [LEN_W-1:0]    mask_now      = 16'hFFFF;
   logic [23:0]         hdr_low       = '0;
   logic [1:0]          hdr_count     = '0;
   logic                in_payload    = 1'b0;
   logic [LEN_W-1:0]    payload_left  = '0;
   logic [FLAGS_W-1:0]  cur_flags     = '0;

   result_type          frame_results_due[$];
   int unsigned         bytes_sent     = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         sender_idle_pct = 0;
   int unsigned         rcv_stall_pct   = 0;

   length_prefixed_frame_splitter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_flags  (rsp_frame_flags),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_size_mask    (csr_size_mask)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the deframing state by one accepted byte; queue its result
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      result_type         r;
      logic [31:0]        word;
      logic [LEN_W-1:0]   len;
      r = '0;
      if (in_payload && payload_left != 0) begin
         r.kind         = KIND_PAYLOAD;
         r.payload_byte = b;
         r.frame_flags  = cur_flags;
         r.last         = (payload_left == 1);
         frame_results_due.insert(frame_results_due.size(), r);
         payload_left = payload_left - 1'b1;
         if (r.last) begin
            in_payload = 1'b0;
         end
         return;
      end
      in_payload = 1'b0;

      // Collect the three low header bytes
      if (hdr_count < 3) begin
         hdr_low[8*hdr_count +: 8] = b;
         hdr_count = hdr_count + 1'b1;
         return;
      end

      // Fourth byte: decode the header with the current mask
      word      = {b, hdr_low};
      len       = word[15:0] & mask_now;
      hdr_low   = '0;
      hdr_count = '0;
      if (word == 0) begin
         r.kind = KIND_ZERO_HDR;
         frame_results_due.insert(frame_results_due.size(), r);
      end else if (len == 0) begin
         r.kind        = KIND_EMPTY;
         r.frame_flags = word[31:16];
         r.last        = 1'b1;
         frame_results_due.insert(frame_results_due.size(), r);
      end else begin
         in_payload   = 1'b1;
         payload_left = len;
         cur_flags    = word[31:16];
      end
   endfunction

   // Receiver: stall at the current rate
   always @(posedge clock) begin
      rsp_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
   end

   // Check each result transaction against the oldest prediction
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_results_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none,", $time,
                     " got kind=%0d byte=%02h flags=%04h last=%0d",
                     rsp_kind, rsp_payload_byte, rsp_frame_flags, rsp_last);
         end else begin
            exp_r = frame_results_due[0];
            frame_results_due.delete(0);
            if (rsp_kind !== exp_r.kind || rsp_payload_byte !== exp_r.payload_byte ||
                rsp_frame_flags !== exp_r.frame_flags || rsp_last !== exp_r.last) begin
               mismatch_count++;
               $display("%0t: result mismatch,", $time,
                        " expected kind=%0d byte=%02h flags=%04h last=%0d,",
                        exp_r.kind, exp_r.payload_byte, exp_r.frame_flags, exp_r.last,
                        " got kind=%0d byte=%02h flags=%04h last=%0d",
                        rsp_kind, rsp_payload_byte, rsp_frame_flags, rsp_last);
            end
         end
      end
   end

   // Send one stream byte, idling first at the current rate
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      deframe_byte(b);
      bytes_sent++;
   endtask

   // Send a header word, low byte first
   task automatic send_header(input logic [31:0] word);
      for (int i = 0; i < 4; i++) begin
         send_byte(word[8*i +: 8]);
      end
   endtask

   // Send random payload bytes until the current frame is complete
   task automatic finish_frame();
      while (in_payload && payload_left != 0) begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // Hold off until every result is in and the pipeline has emptied
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   // Write size_mask while the block is idle
   task automatic set_size_mask(input logic [LEN_W-1:0] m);
      wait_drained();
      csr_valid     <= 1'b1;
      csr_size_mask <= m;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      mask_now = m;
   endtask

   task automatic set_pressure(input int unsigned send_pct, input int unsigned stall_pct);
      sender_idle_pct = send_pct;
      rcv_stall_pct   = stall_pct;
   endtask

   // Reset mask: one-byte frame, zero header, empty frame
   task automatic test_basic_frames();
      set_pressure(0, 0);
      send_header(32'hFFFF_0001);
      send_byte(8'hFF);
      send_header(32'h0000_0000);
      send_header(32'h8001_0000);
   endtask

   // Mask of zero turns any nonzero header into an empty frame; single-bit mask
   task automatic test_mask_extremes();
      set_pressure(12, 12);
      set_size_mask(16'h0000);
      send_header(32'h0000_0001);
      set_size_mask(16'h0001);
      send_header(32'h1234_FFFF);
      send_byte(8'h00);
   endtask

   // A mask write inside a payload leaves the current frame alone
   task automatic test_mask_change_mid_frame();
      set_pressure(0, 54);
      set_size_mask(16'hFFFF);
      send_header(32'h00AA_0003);
      send_byte(8'h80);
      set_size_mask(16'h0000);
      send_byte(8'h7F);
      send_byte(8'h01);
   endtask

   // Long payload whose length uses the upper byte of the count
   task automatic test_long_frame();
      set_pressure(0, 0);
      set_size_mask(16'hFFFF);
      send_header(32'h5A5A_0100);
      finish_frame();
   endtask

   // Random frames: mostly short payloads, some empty, zero and long headers
   task automatic test_random_stream(input logic [LEN_W-1:0] m, input int unsigned send_pct,
                                     input int unsigned stall_pct, input int unsigned count);
      int unsigned        start;
      int unsigned        pick;
      int unsigned        cap;
      logic [FLAGS_W-1:0] flags;
      logic [15:0]        low16;
      set_size_mask(m);
      set_pressure(send_pct, stall_pct);
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         pick = $urandom_range(99);
         cap  = (pick < 80) ? 12 : (pick < 97) ? 64 : 255;
         case ($urandom_range(9))
            0:       flags = 16'h0000;
            1:       flags = 16'hFFFF;
            default: flags = 16'($urandom_range(16'hFFFF));
         endcase
         // Keep the length short; bits outside the mask stay random
         low16 = 16'($urandom_range(16'hFFFF));
         if ((low16 & mask_now) > cap) begin
            low16 = (low16 & ~mask_now) | (16'($urandom_range(cap)) & mask_now);
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_header(32'h0);
         end else if (pick < 20) begin
            send_header({flags, low16 & ~mask_now});
         end else begin
            send_header({flags, low16});
         end
         finish_frame();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_frames();
      test_mask_extremes();
      test_mask_change_mid_frame();
      test_random_stream(16'hFFFF,  0,  0, 160);
      test_random_stream(16'h00FF, 54,  0, 130);
      test_random_stream(16'h0F0F,  0, 54, 130);
      test_random_stream(16'h0000, 12, 12,  90);
      test_random_stream(16'h0001, 54,  0, 110);
      test_random_stream(16'($urandom_range(16'hFFFF)), 0, 54, 150);
      test_random_stream(16'hFFFF, 12, 12, 160);
      test_random_stream(16'h8001,  0,  0, 130);
      test_long_frame();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
